// File: rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and constants
// Transaction structs, operation and status codes, and the link between
// neighboring cells of the sorted insert priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

    localparam int PRIO_W    = 8;
    localparam int DATA_W    = 8;
    localparam int CAP_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [PRIO_W-1:0] in_priority;
        logic [DATA_W-1:0] in_payload;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [PRIO_W-1:0]  out_priority;
        logic [DATA_W-1:0]  out_payload;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } rsp_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] new_prio;
        logic [DATA_W-1:0] new_payload;
    } cell_ctl_t;

    typedef struct packed {
        logic              valid;
        logic              mov;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] payload;
    } cell_link_t;

endpackage

`default_nettype wire

// File: rtl/sorted_insert_priority_queue.sv
// Response: the result strobe rises in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, the cell chain
// updates all of its cells together for each insert or removal.
// Reset: cells empty, count zero, capacity 16; the receiver cannot stall.
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: top level
// Bounded priority queue kept sorted in a row of cells, head in cell zero;
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue
    import sipq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_t             cmd,
    output logic                  done,
    output rsp_t                  result,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    rsp_t             result_reg, result_next;

    logic             accept;
    logic [CW-1:0]    cap_ext, cap_eff, cnt_now, cnt_after;
    logic             full_now, empty_now, enq_ok, deq_ok;
    cell_ctl_t        ctl;
    cell_link_t       links   [DEPTH];
    cell_link_t       left_in [DEPTH];
    cell_link_t       right_in[DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cap_ext = CW'(capacity_reg);
        if (cap_ext == '0)
            cap_eff = CW'(1);
        else if (cap_ext > CW'(DEPTH))
            cap_eff = CW'(DEPTH);
        else
            cap_eff = cap_ext;
    end

    assign cnt_now   = CW'(count_reg);
    assign full_now  = cnt_now >= cap_eff;
    assign empty_now = count_reg == '0;
    assign enq_ok    = accept && (cmd.opcode == OP_ENQ) && !full_now;
    assign deq_ok    = accept && (cmd.opcode == OP_DEQ) && !empty_now;

    assign ctl.enq         = enq_ok;
    assign ctl.deq         = deq_ok;
    assign ctl.new_prio    = cmd.in_priority;
    assign ctl.new_payload = cmd.in_payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_in[gi] = '0;
            end
            else
            begin : g_mid_l
                assign left_in[gi] = links[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in[gi] = '0;
            end
            else
            begin : g_mid_r
                assign right_in[gi] = links[gi+1];
            end
            sipq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .left  (left_in[gi]),
                .right (right_in[gi]),
                .link  (links[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
            count_next = count_reg + CNT_W'(1);
        else if (deq_ok)
            count_next = count_reg - CNT_W'(1);
        cnt_after = CW'(count_next);

        result_next              = '0;
        result_next.status       = ST_OK;
        if (accept && (cmd.opcode == OP_ENQ) && full_now)
            result_next.status = ST_FULL;
        else if (accept && (cmd.opcode == OP_DEQ) && empty_now)
            result_next.status = ST_EMPTY;
        if (deq_ok)
        begin
            result_next.out_priority = links[0].prio;
            result_next.out_payload  = links[0].payload;
        end
        result_next.count    = cnt_after[COUNT_W-1:0];
        result_next.is_empty = count_next == '0;
        result_next.is_full  = cnt_after >= cap_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell: one slot of the sorted chain
// Holds one entry; on enqueue shifts right or captures the new entry at the
// insertion point, on dequeue takes the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell
    import sipq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctl_t  ctl,
    input  wire cell_link_t left,
    input  wire cell_link_t right,
    output cell_link_t      link
);

    logic              valid_reg, valid_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [DATA_W-1:0] payload_reg, payload_next;
    logic              mov;

    assign mov = !valid_reg || (prio_reg > ctl.new_prio);

    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctl.enq && mov)
        begin
            if (left.mov)
            begin
                valid_next   = left.valid;
                prio_next    = left.prio;
                payload_next = left.payload;
            end
            else
            begin
                valid_next   = 1'b1;
                prio_next    = ctl.new_prio;
                payload_next = ctl.new_payload;
            end
        end
        else if (ctl.deq)
        begin
            valid_next   = right.valid;
            prio_next    = right.prio;
            payload_next = right.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign link.valid   = valid_reg;
    assign link.mov     = mov;
    assign link.prio    = prio_reg;
    assign link.payload = payload_reg;

endmodule

`default_nettype wire

// File: rtl/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker: port level checks
// Watches the top level's ports for strobe timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_checker
    import sipq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without accepted transaction");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.count == '0)))
        else $error("empty flag disagrees with count");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.out_priority == '0 && result.out_payload == '0))
        else $error("refused transaction reports an entry");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> result.is_full)
        else $error("enqueue refused while not full");

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// File: tb/tb_sorted_insert_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue: self-checking testbench
// Drives enqueue and dequeue transactions through the command port with
// random gaps. A sorted list model of the queue predicts every response,
// which a monitor compares field by field. The capacity register is changed
// between phases, including values below the held count and out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_insert_priority_queue;

    import sipq_pkg::*;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] payload;
    } qentry_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             done;
    rsp_t             result;
    logic             cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    cmd_t        pending_cmds[$];
    rsp_t        expected_rsp[$];
    qentry_t     sorted_entries[$];
    int unsigned cap_setting = CAP_RESET;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_full_refused = 0;
    int unsigned n_empty_refused = 0;
    int unsigned n_settings = 0;
    int unsigned errors = 0;
    logic        go_idle;
    logic        item_held;

    sorted_insert_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic rsp_t apply_queue_op(cmd_t c);
        rsp_t        r;
        int unsigned lim;
        int          pos;
        qentry_t     e;
        lim = (cap_setting == 0) ? 1 : (cap_setting > DEPTH_DEF) ? DEPTH_DEF : cap_setting;
        r = '0;
        r.status = ST_OK;
        if (c.opcode == OP_ENQ)
        begin
            if (sorted_entries.size() >= lim)
            begin
                r.status = ST_FULL;
                n_full_refused++;
            end
            else
            begin
                pos = sorted_entries.size();
                while (pos > 0 && sorted_entries[pos-1].prio > c.in_priority)
                    pos--;
                e.prio = c.in_priority;
                e.payload = c.in_payload;
                sorted_entries.insert(pos, e);
            end
        end
        else
        begin
            if (sorted_entries.size() == 0)
            begin
                r.status = ST_EMPTY;
                n_empty_refused++;
            end
            else
            begin
                e = sorted_entries.pop_front();
                r.out_priority = e.prio;
                r.out_payload = e.payload;
            end
        end
        r.count = COUNT_W'(sorted_entries.size());
        r.is_empty = (sorted_entries.size() == 0);
        r.is_full = (sorted_entries.size() >= lim);
        return r;
    endfunction

    // driver: hold the item until taken, then advance or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_held = start && busy;
            if (start && !busy)
            begin
                expected_rsp.push_back(apply_queue_op(cmd));
                n_accepted++;
            end
            go_idle = ($urandom_range(0, 99) < 34) && !(n_accepted >= 500 && n_accepted < 680);
            if (!item_held)
            begin
                if (pending_cmds.size() != 0 && !go_idle)
                begin
                    cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
                report_error("response with no transaction outstanding");
            else
            begin
                want = expected_rsp.pop_front();
                n_checked++;
                if (result.status !== want.status)
                    report_error($sformatf("status got %0d want %0d",
                                           result.status, want.status));
                if (result.out_priority !== want.out_priority)
                    report_error($sformatf("out_priority got %0d want %0d",
                                           result.out_priority, want.out_priority));
                if (result.out_payload !== want.out_payload)
                    report_error($sformatf("out_payload got %0d want %0d",
                                           result.out_payload, want.out_payload));
                if (result.count !== want.count)
                    report_error($sformatf("count got %0d want %0d",
                                           result.count, want.count));
                if (result.is_empty !== want.is_empty)
                    report_error($sformatf("is_empty got %0b want %0b",
                                           result.is_empty, want.is_empty));
                if (result.is_full !== want.is_full)
                    report_error($sformatf("is_full got %0b want %0b",
                                           result.is_full, want.is_full));
            end
        end
    end

    task automatic push_cmd(opcode_t op, int unsigned p, int unsigned d);
        cmd_t c;
        c.opcode = op;
        c.in_priority = PRIO_W'(p);
        c.in_payload = DATA_W'(d);
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() != 0 || start || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CAP_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_setting = v;
        n_settings++;
        @(negedge clk);
    endtask

    // alternate fill-heavy and drain-heavy bursts so full and empty are reached
    task automatic random_phase(int n);
        int unsigned enq_pct;
        int unsigned p;
        enq_pct = 80;
        for (int i = 0; i < n; i++)
        begin
            if (i % 24 == 23)
                enq_pct = (enq_pct == 80) ? 25 : 80;
            case ($urandom_range(0, 3))
                0: p = $urandom_range(0, 3);
                1: p = $urandom_range(252, 255);
                default: p = $urandom_range(0, 255);
            endcase
            push_cmd(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ,
                     p, $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int unsigned caps[9];
        caps = '{31, 1, 17, 16, 5, 0, 2, 12, 0};
        caps[8] = $urandom_range(0, 31);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_cmd(OP_DEQ, 8'hFF, 8'hFF);
        push_cmd(OP_ENQ, 255, 8'h00);
        push_cmd(OP_ENQ, 0, 8'hFF);
        push_cmd(OP_ENQ, 128, 8'h11);
        push_cmd(OP_ENQ, 128, 8'h22);
        push_cmd(OP_ENQ, 0, 8'h33);
        push_cmd(OP_ENQ, 255, 8'h44);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_DEQ, 0, 0);
        wait_drained();

        // shrink below the held count
        write_capacity(2);
        push_cmd(OP_ENQ, 7, 8'h55);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_ENQ, 7, 8'h56);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_ENQ, 200, 8'hAA);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_DEQ, 0, 0);
        wait_drained();

        write_capacity(0);
        push_cmd(OP_ENQ, 1, 8'h01);
        push_cmd(OP_ENQ, 2, 8'h02);
        push_cmd(OP_DEQ, 0, 0);
        push_cmd(OP_DEQ, 0, 0);
        wait_drained();

        foreach (caps[k])
        begin
            write_capacity(caps[k]);
            random_phase(120);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        $display("Ran %0d transactions (%0d responses checked) over %0d capacity settings.",
                 n_accepted, n_checked, n_settings);
        $display("Refused: %0d enqueues when full, %0d dequeues when empty.",
                 n_full_refused, n_empty_refused);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d responses outstanding", expected_rsp.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
